### rtl/gfli_pkg.sv
package gfli_pkg;

   // sample and result widths
   localparam int SAMPLE_WIDTH = 32;
   localparam int MAX_GAP      = 63;
   localparam int CNT_WIDTH    = 6;
   localparam int FILL_WIDTH   = 7;
   localparam int DEN_WIDTH    = 7;
   localparam int REM_WIDTH    = 6;

   // iterative divider: bits retired per cycle
   localparam int DIV_STEPS     = 4;
   localparam int DIV_CYCLES    = SAMPLE_WIDTH / DIV_STEPS;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_CYCLES);

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [1:0]              kind_type;

   // result kinds
   localparam kind_type KIND_ORIG   = 2'd0;
   localparam kind_type KIND_EDGE   = 2'd1;
   localparam kind_type KIND_INTERP = 2'd2;
   localparam kind_type KIND_MISS   = 2'd3;

   // one unit of work for the back end: a fill run and an optional closing sample
   typedef struct packed {
      logic [FILL_WIDTH-1:0] fill_cnt;
      kind_type              fill_kind;
      logic                  fill_ovf;
      sample_type            fill_val;
      logic                  tail;
      sample_type            tail_val;
      logic                  seg_end;
   } job_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/gfli_if.sv
interface gfli_req_if;
   import gfli_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       missing;
   logic       seg_end;

   modport source (output valid, sample, missing, seg_end, input ready);
   modport sink (input valid, sample, missing, seg_end, output ready);
endinterface

interface gfli_rsp_if;
   import gfli_pkg::*;

   logic       valid;
   logic       ready;
   sample_type value;
   kind_type   kind;
   logic       overflow;
   logic       seg_last;
   logic       run_last;

   modport source (output valid, value, kind, overflow, seg_last, run_last, input ready);
   modport sink (input valid, value, kind, overflow, seg_last, run_last, output ready);
endinterface

### rtl/gfli_front.sv
module gfli_front (
   input  logic                       clock,
   input  logic                       reset,
   gfli_req_if.sink                   req_if,
   input  gfli_pkg::queue_status_type q_status,
   output logic                       push,
   output gfli_pkg::job_type          push_job
);
   import gfli_pkg::*;

   sample_type             prev_ff, prev_in;
   logic                   have_ff, have_in;
   logic [CNT_WIDTH-1:0]   pend_ff, pend_in;
   logic                   over_ff, over_in;
   logic                   accept;
   logic                   emit;
   job_type                job;

   // a request is taken whenever the queue has room
   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid & req_if.ready;

   // classify the request and work out the next segment state
   always_comb begin
      emit          = 1'b0;
      job.fill_cnt  = '0;
      job.fill_kind = KIND_MISS;
      job.fill_ovf  = 1'b0;
      job.fill_val  = prev_ff;
      job.tail      = 1'b0;
      job.tail_val  = req_if.sample;
      job.seg_end   = req_if.seg_end;
      prev_in       = prev_ff;
      have_in       = have_ff;
      pend_in       = pend_ff;
      over_in       = over_ff;

      if (req_if.missing) begin
         if (over_ff) begin
            // run already overflowed: release each one at once
            emit          = 1'b1;
            job.fill_cnt  = FILL_WIDTH'(1);
            job.fill_ovf  = 1'b1;
         end else if (pend_ff < CNT_WIDTH'(MAX_GAP) && !req_if.seg_end) begin
            // hold the gap, just count it
            pend_in = pend_ff + 1'b1;
         end else if (pend_ff >= CNT_WIDTH'(MAX_GAP)) begin
            // run exceeds the gap limit: dump it unfilled
            emit          = 1'b1;
            job.fill_cnt  = {1'b0, pend_ff} + 1'b1;
            job.fill_ovf  = 1'b1;
            pend_in       = '0;
            over_in       = !req_if.seg_end;
         end else begin
            // segment end: copy last valid sample, else missing
            emit          = 1'b1;
            job.fill_cnt  = {1'b0, pend_ff} + 1'b1;
            job.fill_kind = have_ff ? KIND_EDGE : KIND_MISS;
            pend_in       = '0;
         end
      end else begin
         // valid sample closes any pending run
         emit          = 1'b1;
         job.fill_cnt  = {1'b0, pend_ff};
         job.fill_kind = have_ff ? KIND_INTERP : KIND_EDGE;
         job.fill_val  = have_ff ? prev_ff : req_if.sample;
         job.tail      = 1'b1;
         prev_in       = req_if.sample;
         have_in       = 1'b1;
         pend_in       = '0;
         over_in       = 1'b0;
      end

      if (req_if.seg_end) begin
         prev_in = '0;
         have_in = 1'b0;
         pend_in = '0;
         over_in = 1'b0;
      end
   end

   assign push     = accept & emit;
   assign push_job = job;

   // segment state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         have_ff <= 1'b0;
         pend_ff <= '0;
         over_ff <= 1'b0;
      end else if (accept) begin
         prev_ff <= prev_in;
         have_ff <= have_in;
         pend_ff <= pend_in;
         over_ff <= over_in;
      end
   end

endmodule

### rtl/gfli_queue.sv
module gfli_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gfli_pkg::job_type          push_job,
   input  logic                       pop,
   output gfli_pkg::job_type          head,
   output gfli_pkg::queue_status_type q_status
);
   import gfli_pkg::*;

   job_type                 slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_WIDTH:0]     count_ff, count_in;

   assign q_status.full  = count_ff == (QPTR_WIDTH+1)'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign head           = slot_ff[rd_ptr_ff];

   // pointer and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/gfli_div.sv
module gfli_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  gfli_pkg::sample_type           dividend,
   input  logic [gfli_pkg::DEN_WIDTH-1:0] divisor,
   output logic                           done,
   output gfli_pkg::sample_type           quot,
   output logic [gfli_pkg::REM_WIDTH-1:0] rem
);
   import gfli_pkg::*;

   sample_type                quo_ff, quo_in;
   logic [DEN_WIDTH-1:0]      part_ff, part_in;
   logic [DEN_WIDTH-1:0]      den_ff;
   logic [DIV_CNT_WIDTH-1:0]  step_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic                      last_step;

   assign last_step = step_ff == DIV_CNT_WIDTH'(DIV_CYCLES - 1);

   // restoring division, a few quotient bits per cycle
   always_comb begin
      logic [DEN_WIDTH:0] trial;
      quo_in  = quo_ff;
      part_in = part_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial  = {part_in, quo_in[SAMPLE_WIDTH-1]};
         quo_in = {quo_in[SAMPLE_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         part_in = trial[DEN_WIDTH-1:0];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff & last_step;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         part_ff <= '0;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         quo_ff  <= quo_in;
         part_ff <= part_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = part_ff[REM_WIDTH-1:0];

endmodule

### rtl/gfli_back.sv
module gfli_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gfli_pkg::job_type          head,
   input  gfli_pkg::queue_status_type q_status,
   output logic                       pop,
   gfli_rsp_if.source                 rsp_if
);
   import gfli_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;
   localparam logic [1:0] ST_TAIL = 2'd3;

   logic [1:0]             state_ff, state_in;
   job_type                job_ff;
   logic [FILL_WIDTH-1:0]  cnt_ff, cnt_in;
   sample_type             val_ff, val_in;
   sample_type             a_ff;
   logic [REM_WIDTH-1:0]   r_ff;
   logic [REM_WIDTH-1:0]   racc_ff, racc_in;
   logic                   up_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   sample_type             rsp_value_ff;
   kind_type               rsp_kind_ff;
   logic                   rsp_ovf_ff;
   logic                   rsp_seg_last_ff;
   logic                   rsp_run_last_ff;

   logic                   out_free;
   logic                   emit;
   sample_type             emit_value;
   kind_type               emit_kind;
   logic                   emit_ovf;
   logic                   emit_seg_last;
   logic                   emit_run_last;

   logic                   head_up;
   sample_type             head_mag;
   logic                   div_start;
   logic                   div_done;
   sample_type             div_quot;
   logic [REM_WIDTH-1:0]   div_rem;

   logic [DEN_WIDTH-1:0]   den;
   logic [REM_WIDTH:0]     rem_sum;
   logic                   carry;
   sample_type             step_val;
   logic                   last_fill;

   assign out_free = !rsp_valid_ff | rsp_if.ready;

   // gap magnitude and direction for the job at the queue head
   assign head_up   = $signed(head.tail_val) >= $signed(head.fill_val);
   assign head_mag  = head_up ? head.tail_val - head.fill_val : head.fill_val - head.tail_val;
   assign pop       = (state_ff == ST_IDLE) & !q_status.empty;
   assign div_start = pop & (head.fill_kind == KIND_INTERP) & (head.fill_cnt != '0);

   gfli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head_mag),
      .divisor  (DEN_WIDTH'(head.fill_cnt) + 1'b1),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // next interpolated value: step by the quotient plus one when the remainder wraps
   assign den      = DEN_WIDTH'(job_ff.fill_cnt) + 1'b1;
   assign rem_sum  = {1'b0, racc_ff} + {1'b0, r_ff};
   assign carry    = rem_sum >= den;
   assign step_val = up_ff ? val_ff + a_ff + SAMPLE_WIDTH'(carry)
                           : val_ff - a_ff - SAMPLE_WIDTH'(carry);
   assign last_fill = cnt_ff == FILL_WIDTH'(1);

   // result selection
   always_comb begin
      emit          = 1'b0;
      emit_value    = job_ff.tail_val;
      emit_kind     = KIND_ORIG;
      emit_ovf      = 1'b0;
      emit_run_last = 1'b1;
      emit_seg_last = job_ff.seg_end;
      case (state_ff)
         ST_FILL: begin
            emit          = out_free;
            emit_kind     = job_ff.fill_kind;
            emit_ovf      = job_ff.fill_ovf;
            emit_run_last = last_fill & !job_ff.tail;
            emit_seg_last = last_fill & !job_ff.tail & job_ff.seg_end;
            case (job_ff.fill_kind)
               KIND_INTERP: emit_value = step_val;
               KIND_MISS:   emit_value = '0;
               default:     emit_value = job_ff.fill_val;
            endcase
         end
         ST_TAIL: begin
            emit = out_free;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      racc_in  = racc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cnt_in  = head.fill_cnt;
               val_in  = head.fill_val;
               racc_in = '0;
               if (div_start) begin
                  state_in = ST_DIV;
               end else if (head.fill_cnt != '0) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (emit) begin
               cnt_in  = cnt_ff - 1'b1;
               val_in  = step_val;
               racc_in = carry ? REM_WIDTH'(rem_sum - (REM_WIDTH+1)'(den))
                               : rem_sum[REM_WIDTH-1:0];
               if (last_fill) begin
                  state_in = job_ff.tail ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // job context and interpolation accumulators
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      racc_ff <= racc_in;
      if (pop) begin
         job_ff <= head;
         up_ff  <= head_up;
      end
      if (div_done) begin
         a_ff <= div_quot;
         r_ff <= div_rem;
      end
   end

   // response output register
   assign rsp_valid_in = emit | (rsp_valid_ff & !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff    <= emit_value;
         rsp_kind_ff     <= emit_kind;
         rsp_ovf_ff      <= emit_ovf;
         rsp_seg_last_ff <= emit_seg_last;
         rsp_run_last_ff <= emit_run_last;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.value    = rsp_value_ff;
   assign rsp_if.kind     = rsp_kind_ff;
   assign rsp_if.overflow = rsp_ovf_ff;
   assign rsp_if.seg_last = rsp_seg_last_ff;
   assign rsp_if.run_last = rsp_run_last_ff;

endmodule

### rtl/gap_fill_linear_interp_unit.sv
// Gap filler for one stream of 32-bit signed samples.
// Request channel (req_if): sample, missing mark and segment-end mark.
// Response channel (rsp_if): value, kind (original, edge copy, interpolated,
// left missing), overflow, seg_last and run_last; run_last marks the final
// response caused by one request, and a missing request inside a short gap
// causes none until the gap closes.
// A valid sample with no open gap is stored in a queue slot, picked up by
// the sequencer into its tail state and then held in the output register;
// the sequencer finishes one job before it picks up the next.
// A gap closed by a valid sample is held as a count while its requests are
// taken, then its job is picked up, the gap divider runs (4 quotient bits
// per cycle over 32 bits), the filled responses go out and the closing
// sample follows. Edge copies and runs released unfilled skip the divider.
// A two-entry job queue sits between the request side and the response
// sequencer, so requests keep being taken while responses stall.
// Reset (synchronous) clears the segment state, the queue and the output
// register. When the receiver holds ready low, the response holds steady,
// the sequencer waits, and requests stop once the queue is full.
module gap_fill_linear_interp_unit (
   input  logic       clock,
   input  logic       reset,
   gfli_req_if.sink   req_if,
   gfli_rsp_if.source rsp_if
);
   import gfli_pkg::*;

   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head;
   queue_status_type q_status;

   // classify requests and track the segment
   gfli_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // decoupling queue
   gfli_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // expand jobs into responses
   gfli_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

### rtl/gfli_checker.sv
module gfli_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input gfli_pkg::sample_type rsp_value,
   input gfli_pkg::kind_type   rsp_kind,
   input logic                 rsp_overflow,
   input logic                 rsp_seg_last,
   input logic                 rsp_run_last
);
   import gfli_pkg::*;

   // after reset the block is empty and ready for requests
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response pending or request side blocked after reset");

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_kind))
      else $error("stalled response changed");

   // samples left missing carry a zero value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_MISS |-> rsp_value == '0)
      else $error("missing response with nonzero value");

   // only unfilled samples are flagged for overflow
   a_ovf_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_kind == KIND_MISS)
      else $error("overflow flag on a filled response");

   // the response closing a segment also closes its request
   a_seg_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seg_last |-> rsp_run_last)
      else $error("segment closed before the end of the request's responses");

endmodule

bind gap_fill_linear_interp_unit gfli_checker u_gfli_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_value    (rsp_if.value),
   .rsp_kind     (rsp_if.kind),
   .rsp_overflow (rsp_if.overflow),
   .rsp_seg_last (rsp_if.seg_last),
   .rsp_run_last (rsp_if.run_last)
);
